FILE: rtl/core/ir_pulse_frame_encoder_assert.svh
// assertion macros for the ir pulse frame encoder checker
// expects clk and rst_n in the scope of each use
`ifndef IR_PULSE_FRAME_ENCODER_ASSERT_SVH
`define IR_PULSE_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define IPFE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ipfe assertion failed");

// next-cycle implication
`define IPFE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ipfe assertion failed");

`endif

FILE: rtl/core/ipfe_pkg.sv
// shared types, constants and helpers of the ir pulse frame encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ipfe_pkg;

  localparam int TICK_COUNT_WIDTH = 8;
  localparam int unsigned COUNT_MAX = (2 ** TICK_COUNT_WIDTH) - 1;
  localparam int CFG_IDX_W = 3;
  localparam int FRAME_SYMBOLS = 7;

  typedef logic [TICK_COUNT_WIDTH-1:0] tick_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ON  = 3'd0,
    REG_START_OFF = 3'd1,
    REG_ONE_ON    = 3'd2,
    REG_ONE_OFF   = 3'd3,
    REG_ZERO_ON   = 3'd4,
    REG_ZERO_OFF  = 3'd5
  } cfg_reg_t;

  localparam logic [7:0] RST_START_ON  = 8'd39;
  localparam logic [7:0] RST_START_OFF = 8'd20;
  localparam logic [7:0] RST_ONE_ON    = 8'd43;
  localparam logic [7:0] RST_ONE_OFF   = 8'd16;
  localparam logic [7:0] RST_ZERO_ON   = 8'd15;
  localparam logic [7:0] RST_ZERO_OFF  = 8'd16;

  localparam logic [7:0] CMD_ADDR_STEP = 8'h63; // 'c'
  localparam logic [7:0] CMD_DIGIT_LO  = 8'h30; // '0'
  localparam logic [7:0] CMD_DIGIT_HI  = 8'h34; // '4'

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  // effective phase lengths, already clamped to the counter reach
  typedef struct packed {
    tick_cnt_t start_on;
    tick_cnt_t start_off;
    tick_cnt_t one_on;
    tick_cnt_t one_off;
    tick_cnt_t zero_on;
    tick_cnt_t zero_off;
  } phase_lens_t;

  // zero acts as one, large values saturate at the counter max
  function automatic tick_cnt_t phase_len(input logic [7:0] raw);
    int unsigned v;
    v = int'(raw);
    if (v == 0) v = 1;
    if (v > COUNT_MAX) v = COUNT_MAX;
    return TICK_COUNT_WIDTH'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ipfe_cfg_regs.sv
// configuration register bank with phase length clamping
// depends on ipfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipfe_cfg_regs
  import ipfe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output phase_lens_t               lens
);

  logic [7:0] start_on_r, start_off_r, one_on_r, one_off_r, zero_on_r, zero_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_on_r  <= RST_START_ON;
      start_off_r <= RST_START_OFF;
      one_on_r    <= RST_ONE_ON;
      one_off_r   <= RST_ONE_OFF;
      zero_on_r   <= RST_ZERO_ON;
      zero_off_r  <= RST_ZERO_OFF;
    end else if (cfg_valid) begin
      // writes beyond the register list are dropped
      case (cfg_index)
        REG_START_ON:  start_on_r  <= cfg_data;
        REG_START_OFF: start_off_r <= cfg_data;
        REG_ONE_ON:    one_on_r    <= cfg_data;
        REG_ONE_OFF:   one_off_r   <= cfg_data;
        REG_ZERO_ON:   zero_on_r   <= cfg_data;
        REG_ZERO_OFF:  zero_off_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lens.start_on  = phase_len(start_on_r);
    lens.start_off = phase_len(start_off_r);
    lens.one_on    = phase_len(one_on_r);
    lens.one_off   = phase_len(one_off_r);
    lens.zero_on   = phase_len(zero_on_r);
    lens.zero_off  = phase_len(zero_off_r);
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipfe_frame_core.sv
// frame sequencer: address, symbol and tick counters plus result register
// depends on ipfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipfe_frame_core
  import ipfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  phase_lens_t     lens,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_cmd_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_carrier_on,
  output logic            out_busy_res,
  output logic            out_frame_end,
  output logic [1:0]      out_address_now,
  output logic            out_cmd_ignored
);

  logic [1:0] addr_r, addr_nxt;
  logic       sending_r, sending_nxt;
  logic [6:0] frame_bits_r, frame_bits_nxt;
  logic [2:0] sym_r, sym_nxt;
  logic       off_r, off_nxt;
  tick_cnt_t  tick_r, tick_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       carrier_r, carrier_nxt;
  logic       fend_r, fend_nxt;
  logic       ignored_r, ignored_nxt;

  logic       in_acc;
  logic       sym_bit;
  tick_cnt_t  len_on, len_off, len_cur;
  logic       phase_done;
  logic [3:0] digit;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    sym_bit = frame_bits_r[3'(3'd6 - sym_r)];
    if (sym_r == 3'd0) begin
      len_on  = lens.start_on;
      len_off = lens.start_off;
    end else if (sym_bit) begin
      len_on  = lens.one_on;
      len_off = lens.one_off;
    end else begin
      len_on  = lens.zero_on;
      len_off = lens.zero_off;
    end
    len_cur    = off_r ? len_off : len_on;
    phase_done = ({1'b0, tick_r} + 1'b1) >= {1'b0, len_cur};
    digit      = 4'(in_cmd_byte - CMD_DIGIT_LO);
  end

  always_comb begin
    addr_nxt       = addr_r;
    sending_nxt    = sending_r;
    frame_bits_nxt = frame_bits_r;
    sym_nxt        = sym_r;
    off_nxt        = off_r;
    tick_nxt       = tick_r;
    carrier_nxt    = 1'b0;
    fend_nxt       = 1'b0;
    ignored_nxt    = 1'b0;
    if (in_req_type == REQ_CMD) begin
      if (sending_r) begin
        ignored_nxt = 1'b1;
      end else if (in_cmd_byte == CMD_ADDR_STEP) begin
        addr_nxt = addr_r + 2'd1;
      end else if (in_cmd_byte >= CMD_DIGIT_LO && in_cmd_byte <= CMD_DIGIT_HI) begin
        frame_bits_nxt = {1'b1, addr_r, digit};
        sending_nxt    = 1'b1;
        sym_nxt        = 3'd0;
        off_nxt        = 1'b0;
        tick_nxt       = '0;
      end
    end else if (sending_r) begin
      carrier_nxt = !off_r;
      if (phase_done) begin
        tick_nxt = '0;
        off_nxt  = !off_r;
        if (off_r) begin
          // end of a symbol's off phase
          if (sym_r >= 3'(FRAME_SYMBOLS - 1)) begin
            fend_nxt    = 1'b1;
            sending_nxt = 1'b0;
            sym_nxt     = 3'd0;
          end else begin
            sym_nxt = sym_r + 3'd1;
          end
        end
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (in_acc) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      sending_r    <= 1'b0;
      frame_bits_r <= '0;
      sym_r        <= '0;
      off_r        <= 1'b0;
      tick_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        addr_r       <= addr_nxt;
        sending_r    <= sending_nxt;
        frame_bits_r <= frame_bits_nxt;
        sym_r        <= sym_nxt;
        off_r        <= off_nxt;
        tick_r       <= tick_nxt;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      carrier_r <= carrier_nxt;
      fend_r    <= fend_nxt;
      ignored_r <= ignored_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_carrier_on  = carrier_r;
  assign out_busy_res    = sending_r;
  assign out_frame_end   = fend_r;
  assign out_address_now = addr_r;
  assign out_cmd_ignored = ignored_r;

endmodule

`default_nettype wire

FILE: rtl/core/ir_pulse_frame_encoder.sv
// ir pulse frame encoder top level: the result is registered and valid in the cycle after input accept
// throughput one item per cycle; input stalls only while a result waits stalled
// the sequencer update and result register load happen in the same cycle
// synchronous active-low reset: address and frame state clear, lengths take defaults
// instantiates ipfe_cfg_regs and ipfe_frame_core, depends on ipfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_frame_encoder
  import ipfe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic [7:0]           in_cmd_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_carrier_on,
  output logic                      out_busy_res,
  output logic                      out_frame_end,
  output logic [1:0]                out_address_now,
  output logic                      out_cmd_ignored
);

  phase_lens_t lens;

  assign cfg_ready = 1'b1;

  ipfe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lens      (lens)
  );

  ipfe_frame_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .lens            (lens),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_cmd_byte     (in_cmd_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_carrier_on  (out_carrier_on),
    .out_busy_res    (out_busy_res),
    .out_frame_end   (out_frame_end),
    .out_address_now (out_address_now),
    .out_cmd_ignored (out_cmd_ignored)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ipfe_checker.sv
// port-level checker for the ir pulse frame encoder, bound to the top level
// depends on ipfe_pkg and ir_pulse_frame_encoder_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_frame_encoder_assert.svh"

module ipfe_checker
  import ipfe_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_carrier_on,
  input wire logic       out_busy_res,
  input wire logic       out_frame_end,
  input wire logic [1:0] out_address_now,
  input wire logic       out_cmd_ignored
);

  // the last off tick closes the frame
  `IPFE_ASSERT_NOW(a_fend_not_busy, out_valid && out_frame_end, !out_busy_res)
  // an on tick never ends a frame
  `IPFE_ASSERT_NOW(a_carrier_busy, out_valid && out_carrier_on, out_busy_res && !out_frame_end)
  // a dropped command leaves the frame running and passes no tick
  `IPFE_ASSERT_NOW(a_ignored_busy, out_valid && out_cmd_ignored,
                   out_busy_res && !out_carrier_on && !out_frame_end)
  // a stalled result holds
  `IPFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_busy_res) && $stable(out_address_now))

endmodule

bind ir_pulse_frame_encoder ipfe_checker u_ipfe_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the ir pulse frame encoder: directed and random item streams
// with random idling and back-pressure, checked against an in-bench behavioral predictor
// depends on ipfe_pkg and the ir_pulse_frame_encoder top level
`timescale 1ns / 1ps

module testbench;
  import ipfe_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic       carrier_on;
    logic       busy_res;
    logic       frame_end;
    logic [1:0] address_now;
    logic       cmd_ignored;
  } ir_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [7:0]           in_cmd_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_carrier_on;
  logic                 out_busy_res;
  logic                 out_frame_end;
  logic [1:0]           out_address_now;
  logic                 out_cmd_ignored;

  ir_pulse_frame_encoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_cmd_byte     (in_cmd_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_carrier_on  (out_carrier_on),
    .out_busy_res    (out_busy_res),
    .out_frame_end   (out_frame_end),
    .out_address_now (out_address_now),
    .out_cmd_ignored (out_cmd_ignored)
  );

  // predictor copy of the encoder state and the length registers
  logic [7:0] len_reg [0:5];
  logic [1:0] enc_addr;
  logic       enc_sending;
  logic [6:0] enc_frame;
  logic [2:0] enc_sym;
  logic       enc_off;
  tick_cnt_t  enc_ticks;

  ir_result_t expected_outputs [$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         items_sent = 0;
  int         rx_wait = 0;
  bit         rx_hold = 1'b0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_encoder_model();
    len_reg[REG_START_ON]  = RST_START_ON;
    len_reg[REG_START_OFF] = RST_START_OFF;
    len_reg[REG_ONE_ON]    = RST_ONE_ON;
    len_reg[REG_ONE_OFF]   = RST_ONE_OFF;
    len_reg[REG_ZERO_ON]   = RST_ZERO_ON;
    len_reg[REG_ZERO_OFF]  = RST_ZERO_OFF;
    enc_addr    = 2'd0;
    enc_sending = 1'b0;
    enc_frame   = 7'd0;
    enc_sym     = 3'd0;
    enc_off     = 1'b0;
    enc_ticks   = '0;
  endfunction

  // zero counts as one tick, anything past the counter reach saturates
  function automatic int unsigned eff_len(input logic [7:0] raw);
    int unsigned v;
    v = raw;
    if (v == 0) v = 1;
    if (v > COUNT_MAX) v = COUNT_MAX;
    return v;
  endfunction

  function automatic ir_result_t encode_item(input logic req, input logic [7:0] cmd);
    ir_result_t r;
    cfg_reg_t   on_reg;
    cfg_reg_t   off_reg;
    r = '0;
    if (req == REQ_CMD) begin
      if (enc_sending) begin
        r.cmd_ignored = 1'b1;
      end else if (cmd == CMD_ADDR_STEP) begin
        enc_addr = enc_addr + 2'd1;
      end else if (cmd >= CMD_DIGIT_LO && cmd <= CMD_DIGIT_HI) begin
        enc_frame   = {1'b1, enc_addr, 4'(cmd - CMD_DIGIT_LO)};
        enc_sending = 1'b1;
        enc_sym     = 3'd0;
        enc_off     = 1'b0;
        enc_ticks   = '0;
      end
    end else if (enc_sending) begin
      if (enc_sym == 3'd0) begin
        on_reg  = REG_START_ON;
        off_reg = REG_START_OFF;
      end else if (enc_frame[6 - enc_sym]) begin
        on_reg  = REG_ONE_ON;
        off_reg = REG_ONE_OFF;
      end else begin
        on_reg  = REG_ZERO_ON;
        off_reg = REG_ZERO_OFF;
      end
      if (!enc_off) begin
        r.carrier_on = 1'b1;
        if (int'(enc_ticks) + 1 >= eff_len(len_reg[on_reg])) begin
          enc_off   = 1'b1;
          enc_ticks = '0;
        end else begin
          enc_ticks = enc_ticks + 1'b1;
        end
      end else begin
        if (int'(enc_ticks) + 1 >= eff_len(len_reg[off_reg])) begin
          enc_off   = 1'b0;
          enc_ticks = '0;
          if (enc_sym >= 3'(FRAME_SYMBOLS - 1)) begin
            r.frame_end = 1'b1;
            enc_sending = 1'b0;
            enc_sym     = 3'd0;
          end else begin
            enc_sym = enc_sym + 3'd1;
          end
        end else begin
          enc_ticks = enc_ticks + 1'b1;
        end
      end
    end
    r.busy_res    = enc_sending;
    r.address_now = enc_addr;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [1:0] want_v,
                               input logic [1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
      error_count++;
    end
  endtask

  // result check first, then register writes, then prediction of the accepted item
  always @(posedge clk) begin : monitor
    ir_result_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        rx_wait = rx_idle_en ? $urandom_range(0, 7) : 0;
        if (expected_outputs.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual %b", $time,
                   {out_carrier_on, out_busy_res, out_frame_end, out_address_now,
                    out_cmd_ignored});
          error_count++;
        end else begin
          want = expected_outputs.pop_front();
          compare_field("carrier_on", want.carrier_on, out_carrier_on);
          compare_field("busy_res", want.busy_res, out_busy_res);
          compare_field("frame_end", want.frame_end, out_frame_end);
          compare_field("address_now", want.address_now, out_address_now);
          compare_field("cmd_ignored", want.cmd_ignored, out_cmd_ignored);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index <= REG_ZERO_OFF) len_reg[cfg_index] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        expected_outputs.push_back(encode_item(in_req_type, in_cmd_byte));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin : receiver
    out_stall <= (rx_hold || rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("ir_pulse_frame_encoder regression: fail");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_item(input logic req, input logic [7:0] cmd);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_cmd_byte <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic finish_frame();
    while (enc_sending) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic load_lengths(input logic [7:0] s_on, s_off, o_on, o_off, z_on, z_off);
    finish_frame();
    wait_drain();
    write_reg(REG_START_ON, s_on);
    write_reg(REG_START_OFF, s_off);
    write_reg(REG_ONE_ON, o_on);
    write_reg(REG_ONE_OFF, o_off);
    write_reg(REG_ZERO_ON, z_on);
    write_reg(REG_ZERO_OFF, z_off);
  endtask

  // biased toward the command codes and their neighbors
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return CMD_ADDR_STEP;
      1: return CMD_DIGIT_LO + 8'($urandom_range(0, 4));
      2: return $urandom_range(0, 1) ? CMD_DIGIT_LO - 8'd1 : CMD_DIGIT_HI + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // short lengths keep random frames cheap; zero shows up now and then
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'd0;
    return 8'($urandom_range(1, 6));
  endfunction

  // digit command, then ticks until the frame is out; noisy adds commands while busy
  task automatic run_frame(input logic [7:0] digit, input bit noisy);
    send_item(REQ_CMD, digit);
    while (enc_sending) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(REQ_CMD, pick_byte());
      else send_item(REQ_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_idle_items();
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, CMD_DIGIT_LO + 8'd3);
    send_item(REQ_CMD, 8'h00);
    send_item(REQ_CMD, 8'hFF);
    send_item(REQ_CMD, CMD_DIGIT_LO - 8'd1);
    send_item(REQ_CMD, CMD_DIGIT_HI + 8'd1);
    send_item(REQ_CMD, CMD_ADDR_STEP - 8'd1);
    send_item(REQ_CMD, CMD_ADDR_STEP + 8'd1);
    // address wraps after four steps
    repeat (5) send_item(REQ_CMD, CMD_ADDR_STEP);
    send_item(REQ_TICK, 8'hFF);
  endtask

  task automatic test_default_frame();
    send_item(REQ_CMD, CMD_DIGIT_HI);
    send_item(REQ_CMD, CMD_ADDR_STEP);
    send_item(REQ_TICK, 8'h5A);
    send_item(REQ_CMD, CMD_DIGIT_LO);
    send_item(REQ_CMD, 8'hFF);
    send_item(REQ_CMD, 8'h00);
    finish_frame();
    send_item(REQ_TICK, 8'hA5);
    send_item(REQ_CMD, CMD_ADDR_STEP);
  endtask

  task automatic test_short_lengths();
    load_lengths(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_frame(CMD_DIGIT_LO, 1'b0);
    send_item(REQ_CMD, CMD_ADDR_STEP);
    run_frame(CMD_DIGIT_LO + 8'd2, 1'b1);
    load_lengths(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_item(REQ_CMD, CMD_ADDR_STEP);
    run_frame(CMD_DIGIT_LO + 8'd3, 1'b0);
    run_frame(CMD_DIGIT_HI, 1'b1);
  endtask

  // one phase at the top of the counter range
  task automatic test_long_lengths();
    load_lengths(8'd255, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0);
    run_frame(CMD_DIGIT_LO + 8'd3, 1'b1);
  endtask

  task automatic test_backpressure();
    load_lengths(8'd2, 8'd3, 8'd2, 8'd1, 8'd1, 8'd2);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      run_frame(CMD_DIGIT_LO + 8'd2, 1'b1);
    join
    // the sender waits here for every outstanding result
    wait_drain();
    run_frame(CMD_DIGIT_LO + 8'd4, 1'b0);
  endtask

  task automatic test_random();
    int target;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_lengths(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
      if (phase == 1) begin
        write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
        write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
      end
      tx_idle_en = phase[0];
      rx_idle_en = phase[1] | (phase >= 4);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0: send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          1: send_item(REQ_CMD, pick_byte());
          2: wait_drain();
          default: begin
            if ($urandom_range(0, 1)) send_item(REQ_CMD, CMD_ADDR_STEP);
            run_frame(CMD_DIGIT_LO + 8'($urandom_range(0, 4)), 1'b1);
          end
        endcase
      end
    end
    finish_frame();
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = 8'd0;
    in_valid    = 1'b0;
    in_req_type = REQ_TICK;
    in_cmd_byte = 8'd0;
    reset_encoder_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_items();
    test_default_frame();
    test_short_lengths();
    test_long_lengths();
    test_backpressure();
    test_random();

    wait_drain();
    if (expected_outputs.size() != 0) begin
      $display("%0t ns: results missing, expected %0d actual 0", $time,
               expected_outputs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ir_pulse_frame_encoder regression: pass");
    end else begin
      $display("ir_pulse_frame_encoder regression: fail");
    end
    $finish;
  end

endmodule
